/* design/ffwha_pkg.sv */
// ffwha_pkg: shared constants and helpers for the first-fit word heap allocator
// no dependencies

package ffwha_pkg;

    // command codes
    localparam logic [1:0] CMD_RESIZE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // request limits and counter ceiling
    localparam logic [9:0]  MIN_REQ_BYTES = 10'd1;
    localparam logic [9:0]  MAX_REQ_BYTES = 10'd1020;
    localparam logic [15:0] HOLE_MAX      = 16'hFFFF;

    // number of whole words covered by a byte count
    function automatic logic [30:0] words_of(input logic [31:0] bytes);
        logic [32:0] sum;
        begin
            sum = {1'b0, bytes} + 33'd3;
            words_of = sum[32:2];
        end
    endfunction

endpackage

/* design/ffwha_ram.sv */
// ffwha_ram: generic single-write, single-read synchronous RAM
// registered read data; no dependencies

module ffwha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/ffwha_ctrl.sv */
// ffwha_ctrl: command sequencer for the word heap (scan, grow check, copy, clear)
// depends on ffwha_pkg; drives the heap RAM ports

module ffwha_ctrl #(
    parameter int HEAP_WORDS = 256,
    localparam int AW = $clog2(HEAP_WORDS),
    localparam int IW = ((AW + 1) > 10) ? (AW + 1) : 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    cmd,
    input  logic          has_block,
    input  logic [7:0]    base,
    input  logic [9:0]    size_bytes,
    input  logic [31:0]   write_data,
    output logic          busy,
    output logic          done,
    output logic [7:0]    new_base,
    output logic [9:0]    granted_bytes,
    output logic          status,
    output logic [31:0]   read_data,
    output logic [15:0]   hole_count,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [31:0]   ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [31:0]   ram_rdata
);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_RD_WAIT = 14'b00000000000100,
        ST_HDR     = 14'b00000000001000,
        ST_ZERO    = 14'b00000000010000,
        ST_GROW_RD = 14'b00000000100000,
        ST_GROW_EV = 14'b00000001000000,
        ST_SCAN_RD = 14'b00000010000000,
        ST_SCAN_EV = 14'b00000100000000,
        ST_RUN_RD  = 14'b00001000000000,
        ST_RUN_EV  = 14'b00010000000000,
        ST_COPY_RD = 14'b00100000000000,
        ST_COPY_WR = 14'b01000000000000,
        ST_HOLE    = 14'b10000000000000
    } state_t;

    localparam logic [IW-1:0] HEAP_I = IW'(HEAP_WORDS);

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [31:0]   last_reg, last_next;
    logic [7:0]    base_reg, base_next;
    logic [9:0]    sz_reg, sz_next;
    logic [7:0]    need_reg, need_next;
    logic          hasb_reg, hasb_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    run_reg, run_next;
    logic [7:0]    i_reg, i_next;
    logic [AW-1:0] where_reg, where_next;
    logic          done_reg, done_next;
    logic [7:0]    nb_reg, nb_next;
    logic [9:0]    gr_reg, gr_next;
    logic          st_reg, st_next;
    logic [31:0]   rd_reg, rd_next;
    logic [15:0]   holes_reg, holes_next;

    logic [9:0]    sz_in;
    logic [30:0]   cur_w;
    logic [31:0]   scan_sum;
    logic [IW-1:0] src_idx;
    logic [IW-1:0] dst_idx;
    logic          base_in_heap;

    // clamp of the requested size
    always_comb
    begin
        if (size_bytes < ffwha_pkg::MIN_REQ_BYTES)
        begin
            sz_in = ffwha_pkg::MIN_REQ_BYTES;
        end
        else if (size_bytes > ffwha_pkg::MAX_REQ_BYTES)
        begin
            sz_in = ffwha_pkg::MAX_REQ_BYTES;
        end
        else
        begin
            sz_in = size_bytes;
        end
    end

    // shared address arithmetic
    assign base_in_heap = (32'(base) < 32'(HEAP_WORDS));
    assign cur_w        = ffwha_pkg::words_of(ram_rdata);
    assign scan_sum     = 32'(pos_reg) + 32'(cur_w) + 32'd1;
    assign src_idx      = IW'(base_reg) + IW'(i_reg) + IW'(1);
    assign dst_idx      = IW'(where_reg) + IW'(i_reg) + IW'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        base_next  = base_reg;
        sz_next    = sz_reg;
        need_next  = need_reg;
        hasb_next  = hasb_reg;
        cur_next   = cur_reg;
        run_next   = run_reg;
        i_next     = i_reg;
        where_next = where_reg;
        done_next  = 1'b0;
        nb_next    = nb_reg;
        gr_next    = gr_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        holes_next = holes_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (state_reg)
            // sweep zeros through the heap after reset
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg);
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == HEAP_I - IW'(1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // take a new item
            ST_IDLE:
            begin
                if (start)
                begin
                    base_next = base;
                    sz_next   = sz_in;
                    need_next = 8'(ffwha_pkg::words_of(32'(sz_in)));
                    hasb_next = has_block;
                    nb_next   = 8'd0;
                    gr_next   = 10'd0;
                    st_next   = 1'b0;
                    rd_next   = 32'd0;
                    case (cmd)
                        ffwha_pkg::CMD_WRITE:
                        begin
                            nb_next   = base;
                            done_next = 1'b1;
                            if (base_in_heap)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(base);
                                ram_wdata = write_data;
                            end
                        end
                        ffwha_pkg::CMD_READ:
                        begin
                            nb_next = base;
                            if (base_in_heap)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(base);
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ffwha_pkg::CMD_RESIZE:
                        begin
                            if (!has_block)
                            begin
                                pos_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                            else if (!base_in_heap)
                            begin
                                nb_next   = base;
                                st_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                nb_next    = base;
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(base);
                                state_next = ST_HDR;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // heap word read back
            ST_RD_WAIT:
            begin
                rd_next    = ram_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // decide shrink, equal or grow from the current header
            ST_HDR:
            begin
                if (cur_w > 31'(need_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(base_reg);
                    ram_wdata  = 32'(sz_reg);
                    gr_next    = {need_reg, 2'b00};
                    idx_next   = IW'(base_reg) + IW'(need_reg) + IW'(1);
                    last_next  = 32'(base_reg) + 32'(cur_w);
                    state_next = ST_ZERO;
                end
                else if (cur_w == 31'(need_reg))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next   = cur_w[7:0];
                    idx_next   = IW'(base_reg) + IW'(cur_w[7:0]) + IW'(1);
                    state_next = ST_GROW_RD;
                end
            end

            // clear a run of words inside the heap, then count the hole
            ST_ZERO:
            begin
                if (idx_reg < HEAP_I && 32'(idx_reg) <= last_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg);
                    idx_next  = idx_reg + IW'(1);
                end
                else
                begin
                    state_next = ST_HOLE;
                end
            end

            ST_HOLE:
            begin
                if (holes_reg != ffwha_pkg::HOLE_MAX)
                begin
                    holes_next = holes_reg + 16'd1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // check the words needed for growth in place
            ST_GROW_RD:
            begin
                if (idx_reg > IW'(base_reg) + IW'(need_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(base_reg);
                    ram_wdata  = 32'(sz_reg);
                    gr_next    = {need_reg, 2'b00};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (idx_reg >= HEAP_I)
                begin
                    pos_next   = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(idx_reg);
                    state_next = ST_GROW_EV;
                end
            end

            ST_GROW_EV:
            begin
                if (ram_rdata != 32'd0)
                begin
                    pos_next   = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_GROW_RD;
                end
            end

            // first-fit scan: header or free word at pos
            ST_SCAN_RD:
            begin
                if (pos_reg >= HEAP_I)
                begin
                    st_next    = 1'b1;
                    nb_next    = hasb_reg ? base_reg : 8'd0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(pos_reg);
                    state_next = ST_SCAN_EV;
                end
            end

            ST_SCAN_EV:
            begin
                if (ram_rdata != 32'd0)
                begin
                    pos_next   = (scan_sum >= 32'(HEAP_WORDS)) ? HEAP_I : IW'(scan_sum);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    idx_next   = pos_reg + IW'(1);
                    run_next   = 8'd0;
                    state_next = ST_RUN_RD;
                end
            end

            // count the free run after a free word
            ST_RUN_RD:
            begin
                if (run_reg == need_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(pos_reg);
                    ram_wdata  = 32'(sz_reg);
                    where_next = AW'(pos_reg);
                    nb_next    = 8'(pos_reg);
                    gr_next    = {need_reg, 2'b00};
                    if (hasb_reg)
                    begin
                        i_next     = 8'd0;
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg >= HEAP_I)
                begin
                    pos_next   = idx_reg;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(idx_reg);
                    state_next = ST_RUN_EV;
                end
            end

            ST_RUN_EV:
            begin
                if (ram_rdata == 32'd0)
                begin
                    run_next   = run_reg + 8'd1;
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_RUN_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    state_next = ST_SCAN_RD;
                end
            end

            // move: copy each data word by a read state then a write state, then clear the old block
            ST_COPY_RD:
            begin
                if (i_reg == cur_reg)
                begin
                    idx_next   = IW'(base_reg);
                    last_next  = 32'(base_reg) + 32'(cur_reg);
                    state_next = ST_ZERO;
                end
                else
                begin
                    if (src_idx < HEAP_I)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(src_idx);
                    end
                    state_next = ST_COPY_WR;
                end
            end

            ST_COPY_WR:
            begin
                if (dst_idx < HEAP_I)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(dst_idx);
                    ram_wdata = (src_idx < HEAP_I) ? ram_rdata : 32'd0;
                end
                i_next     = i_reg + 8'd1;
                state_next = ST_COPY_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            holes_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            holes_reg <= holes_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        base_reg  <= base_next;
        sz_reg    <= sz_next;
        need_reg  <= need_next;
        hasb_reg  <= hasb_next;
        cur_reg   <= cur_next;
        run_reg   <= run_next;
        i_reg     <= i_next;
        where_reg <= where_next;
        nb_reg    <= nb_next;
        gr_reg    <= gr_next;
        st_reg    <= st_next;
        rd_reg    <= rd_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign new_base      = nb_reg;
    assign granted_bytes = gr_reg;
    assign status        = st_reg;
    assign read_data     = rd_reg;
    assign hole_count    = holes_reg;

endmodule

/* design/first_fit_word_heap_allocator.sv */
// first_fit_word_heap_allocator: top level, heap RAM plus command sequencer
// depends on ffwha_pkg, ffwha_ram, ffwha_ctrl
//
// channel  | signals                                         | handshake
// command  | cmd has_block base size_bytes write_data        | start & !busy
// result   | new_base granted_bytes status read_data         | done strobe, one cycle
//          | hole_count                                      |
//
// a write finishes straight from idle, a read through a wait state; a resize reads
// the heap one word at a time through the single RAM read port: each scanned word or
// header and each checked or copied word is read in one state and used in the next,
// and each cleared word takes a single write.
// after reset the heap is swept to zero word by word with busy high.
// done rises in the cycle after the last step; the receiver cannot stall it.

module first_fit_word_heap_allocator #(
    parameter int HEAP_WORDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic        has_block,
    input  logic [7:0]  base,
    input  logic [9:0]  size_bytes,
    input  logic [31:0] write_data,
    output logic        done,
    output logic [7:0]  new_base,
    output logic [9:0]  granted_bytes,
    output logic        status,
    output logic [31:0] read_data,
    output logic [15:0] hole_count
);

    localparam int AW = $clog2(HEAP_WORDS);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // heap store
    ffwha_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencer
    ffwha_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .has_block     (has_block),
        .base          (base),
        .size_bytes    (size_bytes),
        .write_data    (write_data),
        .busy          (busy),
        .done          (done),
        .new_base      (new_base),
        .granted_bytes (granted_bytes),
        .status        (status),
        .read_data     (read_data),
        .hole_count    (hole_count),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // an accepted item either finishes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither finished nor in progress");

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // the sequencer never reads and writes the heap in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("heap read and write in the same cycle");

    // hole counter only steps up by one
    a_hole_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hole_count != $past(hole_count)) |-> (hole_count == $past(hole_count) + 16'd1))
        else $error("hole counter changed by other than one");

endmodule

/* test/tb_first_fit_word_heap_allocator.sv */
// tb_first_fit_word_heap_allocator: self-checking bench for the first-fit word heap allocator
// depends on ffwha_pkg and first_fit_word_heap_allocator; items are queued by a generator,
// driven by a clocked driver and predicted against a local heap copy as they are accepted

module tb_first_fit_word_heap_allocator;

    localparam int HEAP_DEPTH   = 256;
    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic        has_block;
        logic [7:0]  base;
        logic [9:0]  size_bytes;
        logic [31:0] write_data;
    } heap_item_t;

    typedef struct {
        logic [7:0]  new_base;
        logic [9:0]  granted_bytes;
        logic        status;
        logic [31:0] read_data;
        logic [15:0] hole_count;
    } heap_reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic        has_block;
    logic [7:0]  base;
    logic [9:0]  size_bytes;
    logic [31:0] write_data;
    logic        done;
    logic [7:0]  new_base;
    logic [9:0]  granted_bytes;
    logic        status;
    logic [31:0] read_data;
    logic [15:0] hole_count;

    heap_item_t  pending_items[$];
    heap_reply_t expected_replies[$];
    logic [31:0] model_heap[HEAP_DEPTH];
    logic [15:0] model_holes;
    int          error_count;
    int          stall_cycles;
    bit          calm;

    first_fit_word_heap_allocator #(.HEAP_WORDS(HEAP_DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .has_block(has_block), .base(base), .size_bytes(size_bytes),
        .write_data(write_data), .done(done), .new_base(new_base),
        .granted_bytes(granted_bytes), .status(status), .read_data(read_data),
        .hole_count(hole_count)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // word count covered by a header
    function automatic longint unsigned span_words(input logic [31:0] hdr);
        span_words = (longint'(hdr) + 3) >> 2;
    endfunction

    // first-fit search for a zero header plus need zero words
    function automatic bit find_fit(input longint unsigned need, output longint unsigned at);
        longint unsigned pos;
        longint unsigned q;
        longint unsigned run;
        pos = 0;
        at = 0;
        while (pos < HEAP_DEPTH)
        begin
            if (model_heap[pos] == 32'd0)
            begin
                run = 0;
                q = pos + 1;
                while (q < HEAP_DEPTH && model_heap[q] == 32'd0 && run < need)
                begin
                    run++;
                    q++;
                end
                if (run >= need)
                begin
                    at = pos;
                    return 1'b1;
                end
                pos = q;
            end
            else
                pos += span_words(model_heap[pos]) + 1;
        end
        return 1'b0;
    endfunction

    function automatic void bump_holes();
        if (model_holes != 16'hFFFF)
            model_holes++;
    endfunction

    // apply one item to the heap copy and return its reply
    function automatic heap_reply_t apply_heap_item(input heap_item_t it);
        heap_reply_t     r;
        logic [9:0]      sz;
        longint unsigned need;
        longint unsigned cur;
        longint unsigned at;
        longint unsigned i;
        longint unsigned b;
        bit              blocked;
        r = '{default: '0};
        b = it.base;
        if (it.cmd == ffwha_pkg::CMD_WRITE)
        begin
            r.new_base = it.base;
            model_heap[b] = it.write_data;
        end
        else if (it.cmd == ffwha_pkg::CMD_READ)
        begin
            r.new_base = it.base;
            r.read_data = model_heap[b];
        end
        else if (it.cmd == ffwha_pkg::CMD_RESIZE)
        begin
            sz = it.size_bytes;
            if (sz < ffwha_pkg::MIN_REQ_BYTES)
                sz = ffwha_pkg::MIN_REQ_BYTES;
            if (sz > ffwha_pkg::MAX_REQ_BYTES)
                sz = ffwha_pkg::MAX_REQ_BYTES;
            need = span_words({22'd0, sz});
            if (!it.has_block)
            begin
                if (find_fit(need, at))
                begin
                    model_heap[at] = {22'd0, sz};
                    r.new_base = at[7:0];
                    r.granted_bytes = 10'(need * 4);
                end
                else
                    r.status = 1'b1;
            end
            else
            begin
                cur = span_words(model_heap[b]);
                r.new_base = it.base;
                if (cur > need)
                begin
                    // shrink in place and clear the freed tail
                    model_heap[b] = {22'd0, sz};
                    for (i = b + need + 1; i <= b + cur && i < HEAP_DEPTH; i++)
                        model_heap[i] = 32'd0;
                    bump_holes();
                    r.granted_bytes = 10'(need * 4);
                end
                else if (cur < need)
                begin
                    blocked = 1'b0;
                    for (i = b + cur + 1; i <= b + need; i++)
                    begin
                        if (i >= HEAP_DEPTH || model_heap[i] != 32'd0)
                        begin
                            blocked = 1'b1;
                            break;
                        end
                    end
                    if (!blocked)
                    begin
                        model_heap[b] = {22'd0, sz};
                        r.granted_bytes = 10'(need * 4);
                    end
                    else if (find_fit(need, at))
                    begin
                        // move: copy data words, then clear the old block
                        model_heap[at] = {22'd0, sz};
                        for (i = 0; i < cur; i++)
                            if (at + 1 + i < HEAP_DEPTH)
                                model_heap[at + 1 + i] =
                                    (b + 1 + i < HEAP_DEPTH) ? model_heap[b + 1 + i] : 32'd0;
                        for (i = 0; i <= cur && b + i < HEAP_DEPTH; i++)
                            model_heap[b + i] = 32'd0;
                        bump_holes();
                        r.new_base = at[7:0];
                        r.granted_bytes = 10'(need * 4);
                    end
                    else
                        r.status = 1'b1;
                end
            end
        end
        r.hole_count = model_holes;
        return r;
    endfunction

    // driver: next item goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= ffwha_pkg::CMD_READ;
            has_block <= 1'b0;
            base <= 8'd0;
            size_bytes <= 10'd0;
            write_data <= 32'd0;
        end
        else if (!start || !busy)
        begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 38))
            begin
                heap_item_t it;
                it = pending_items.pop_front();
                cmd <= it.cmd;
                has_block <= it.has_block;
                base <= it.base;
                size_bytes <= it.size_bytes;
                write_data <= it.write_data;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check replies, then predict the item accepted at this edge
    always @(posedge clk)
    begin
        heap_item_t  it;
        heap_reply_t ex;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply with no item outstanding");
                    error_count++;
                end
                else
                begin
                    ex = expected_replies.pop_front();
                    if (new_base !== ex.new_base)
                    begin
                        $error("new_base expected %0d actual %0d", ex.new_base, new_base);
                        error_count++;
                    end
                    if (granted_bytes !== ex.granted_bytes)
                    begin
                        $error("granted_bytes expected %0d actual %0d",
                               ex.granted_bytes, granted_bytes);
                        error_count++;
                    end
                    if (status !== ex.status)
                    begin
                        $error("status expected %0d actual %0d", ex.status, status);
                        error_count++;
                    end
                    if (read_data !== ex.read_data)
                    begin
                        $error("read_data expected %h actual %h", ex.read_data, read_data);
                        error_count++;
                    end
                    if (hole_count !== ex.hole_count)
                    begin
                        $error("hole_count expected %0d actual %0d", ex.hole_count, hole_count);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                it = '{cmd, has_block, base, size_bytes, write_data};
                expected_replies.push_back(apply_heap_item(it));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("first_fit_word_heap_allocator verification failed");
            $finish;
        end
    end

    function automatic void queue_item(input logic [1:0] c, input logic hb, input logic [7:0] b,
                                       input logic [9:0] sz, input logic [31:0] wd);
        heap_item_t it;
        it = '{c, hb, b, sz, wd};
        pending_items.push_back(it);
    endfunction

    // mostly small sizes, now and then anything up to the field limit
    function automatic logic [9:0] pick_size();
        if ($urandom_range(9) == 0)
            return 10'($urandom_range(1023));
        return 10'($urandom_range(48));
    endfunction

    // stimulus
    initial
    begin
        int          sent;
        int          k;
        int          w;
        int          hdrs[$];
        longint unsigned pos;
        logic [7:0]  hb;

        error_count = 0;
        stall_cycles = 0;
        calm = 1'b0;
        model_holes = '0;
        foreach (model_heap[i])
            model_heap[i] = 32'd0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every command, full heap, shrink, equal, grow, move
        queue_item(ffwha_pkg::CMD_READ, 1'b0, 8'd0, 10'd0, 32'd0);
        queue_item(ffwha_pkg::CMD_WRITE, 1'b0, 8'd255, 10'd0, 32'hFFFF_FFFF);
        queue_item(ffwha_pkg::CMD_READ, 1'b1, 8'd255, 10'h3FF, 32'hFFFF_FFFF);
        queue_item(ffwha_pkg::CMD_WRITE, 1'b0, 8'd255, 10'd0, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'd1020, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'd4, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd0, 10'd8, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd0, 10'd5, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd0, 10'd40, 32'd0);
        queue_item(ffwha_pkg::CMD_WRITE, 1'b0, 8'd1, 10'd0, 32'hA5A5_5A5A);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'd0, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'd16, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd0, 10'd100, 32'd0);
        queue_item(ffwha_pkg::CMD_READ, 1'b0, 8'd17, 10'd0, 32'd0);
        queue_item(CMD_UNUSED, 1'b1, 8'd9, 10'd9, 32'd9);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd200, 10'd12, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'd250, 10'd40, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'h3FF, 32'd0);
        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'd0, 10'd1020, 32'd0);

        // random batches built from the current heap layout
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait (pending_items.size() == 0 && expected_replies.size() == 0 && !start);
            calm = (sent >= 180 && sent < 260);
            hdrs.delete();
            pos = 0;
            while (pos < HEAP_DEPTH)
            begin
                if (model_heap[pos] != 32'd0)
                begin
                    hdrs.push_back(int'(pos));
                    pos += span_words(model_heap[pos]) + 1;
                end
                else
                    pos++;
            end
            for (k = 0; k < 8; k++)
            begin
                hb = (hdrs.size() > 0) ? 8'(hdrs[$urandom_range(hdrs.size() - 1)]) : 8'd0;
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, hb, pick_size(), $urandom);
                    8, 9, 10, 11:
                        queue_item(ffwha_pkg::CMD_RESIZE, 1'b0, 8'($urandom), pick_size(),
                                   $urandom);
                    12, 13:
                        queue_item(ffwha_pkg::CMD_READ, 1'($urandom),
                                   $urandom_range(1) ? hb + 8'd1 : 8'($urandom),
                                   10'($urandom), $urandom);
                    14:
                    begin
                        // free a block by zeroing its header and, for spans up to 12 words, its data words
                        w = int'(span_words(model_heap[hb]));
                        if (w > 12)
                            w = 0;
                        for (int j = 0; j <= w && int'(hb) + j < HEAP_DEPTH; j++)
                            queue_item(ffwha_pkg::CMD_WRITE, 1'b0, hb + 8'(j), 10'd0, 32'd0);
                        sent += w;
                    end
                    15:
                        queue_item(ffwha_pkg::CMD_WRITE, 1'($urandom), 8'($urandom),
                                   10'($urandom),
                                   $urandom_range(1) ? $urandom : 32'($urandom_range(64)));
                    16:
                        queue_item(CMD_UNUSED, 1'($urandom), 8'($urandom), 10'($urandom),
                                   $urandom);
                    default:
                        queue_item(ffwha_pkg::CMD_RESIZE, 1'b1, 8'($urandom), 10'($urandom),
                                   $urandom);
                endcase
                sent++;
            end
        end
        calm = 1'b0;

        // drain, then allow the last command to settle
        wait (pending_items.size() == 0 && expected_replies.size() == 0 && !start);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("first_fit_word_heap_allocator verification clean");
        else
            $display("first_fit_word_heap_allocator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/ffwha_pkg.sv
design/ffwha_ram.sv
design/ffwha_ctrl.sv
design/first_fit_word_heap_allocator.sv
test/tb_first_fit_word_heap_allocator.sv
